[rtl/assert_macros.svh]
// assertion helpers used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

[rtl/ble_pkg.sv]
`default_nettype none
package ble_pkg;

   // storage geometry
   localparam int DEPTH  = 128;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int ACT_W     = 4;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 8;
   localparam int CAP_W     = 8;
   localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_FRONT  = 4'd0,
      ACT_INS_BACK   = 4'd1,
      ACT_INS_SORTED = 4'd2,
      ACT_REM_FRONT  = 4'd3,
      ACT_REM_BACK   = 4'd4,
      ACT_REM_VALUE  = 4'd5,
      ACT_CONTAINS   = 4'd6,
      ACT_SORT_UP    = 4'd7,
      ACT_SORT_DOWN  = 4'd8,
      ACT_CLEAR      = 4'd9
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISP,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_UP_RD,
      S_UP_WR,
      S_DN_RD,
      S_DN_WR,
      S_SORT_RD0,
      S_SORT_RD1,
      S_SORT_CMP,
      S_SORT_WR,
      S_RESP
   } fsm_type;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_ZERO, PTR_COUNT, PTR_LAST, PTR_INC, PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {POS_HOLD, POS_ZERO, POS_COUNT, POS_PTR} pos_op_type;
   typedef enum logic [1:0] {RA_PTR, RA_PTR_M1, RA_PTR_P1} raddr_type;
   typedef enum logic {WA_PTR, WA_PTR_P1} waddr_type;
   typedef enum logic [1:0] {WD_RDATA, WD_VALUE, WD_TEMP} wdata_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_type;

   // controller to datapath
   typedef struct packed {
      logic       start;
      ptr_op_type ptr_op;
      pos_op_type pos_op;
      raddr_type  raddr;
      logic       we;
      waddr_type  waddr;
      wdata_type  wdata;
      logic       temp_ld;
      cnt_op_type cnt_op;
      logic       rem_ld;
      logic       found_set;
      logic       stat_ld;
      status_type stat_code;
      logic       swap_clr;
      logic       swap_set;
      logic       res_ld;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             full;
      logic             empty;
      logic             at_end;
      logic             ptr_eq_pos;
      logic             pair_end;
      logic             match;
      logic             swap_need;
      logic             swapped;
      logic             out_free;
   } stat_type;

endpackage
`default_nettype wire

[rtl/ble_if.sv]
`default_nettype none
// request channel: one word per request
interface ble_req_if;
   import ble_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ACT_W-1:0]        action;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

// response channel: one word per request
interface ble_rsp_if;
   import ble_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic signed [VAL_W-1:0] removed_value;
   logic                    found;
   logic [CNT_OUT_W-1:0]    entry_count;
   logic                    is_empty;
   modport source (output valid, output status, output removed_value, output found,
                   output entry_count, output is_empty, input ready);
   modport sink (input valid, input status, input removed_value, input found,
                 input entry_count, input is_empty, output ready);
endinterface
`default_nettype wire

[rtl/bounded_list_engine.sv]
`default_nettype none
// clear and refused requests go from the dispatch state straight to the response state and its output register
// inserts and removals walk the list one entry at a time, a read state and a write or check state per entry
// sorts use bubble passes over the list memory, which has one write port and one read port
// one request at a time; the next is taken once the result sits in the output register
// reset: count 0, capacity 100, no response pending; list storage is not cleared
module bounded_list_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   ble_req_if.sink                        req_bus,
   ble_rsp_if.source                      rsp_bus,
   input  wire logic                      csr_write_enable,
   input  wire logic [ble_pkg::CAP_W-1:0] csr_write_data
);
   import ble_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   ble_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, pointers and result
   ble_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_bus.action),
      .req_value         (req_bus.value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_removed_value (rsp_bus.removed_value),
      .rsp_found         (rsp_bus.found),
      .rsp_entry_count   (rsp_bus.entry_count),
      .rsp_is_empty      (rsp_bus.is_empty)
   );
endmodule
`default_nettype wire

[rtl/ble_ram.sv]
`default_nettype none
module ble_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/ble_ctrl.sv]
`default_nettype none
module ble_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ble_pkg::stat_type stat,
   output ble_pkg::cmd_type       cmd
);
   import ble_pkg::*;

   fsm_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.start = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            case (action_type'(stat.action))
               ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_SORTED: begin
                  if (stat.full) begin
                     cmd.stat_ld   = 1'b1;
                     cmd.stat_code = STAT_FULL;
                     state_in      = S_RESP;
                  end else if (stat.action == ACT_INS_SORTED) begin
                     cmd.ptr_op   = PTR_ZERO;
                     cmd.swap_clr = 1'b1;
                     state_in     = S_SORT_RD0;
                  end else begin
                     cmd.ptr_op = PTR_COUNT;
                     cmd.pos_op = (stat.action == ACT_INS_FRONT) ? POS_ZERO : POS_COUNT;
                     state_in   = S_UP_RD;
                  end
               end
               ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_VALUE: begin
                  if (stat.empty) begin
                     cmd.stat_ld   = 1'b1;
                     cmd.stat_code = STAT_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     cmd.ptr_op = (stat.action == ACT_REM_BACK) ? PTR_LAST : PTR_ZERO;
                     state_in   = S_SRCH_RD;
                  end
               end
               ACT_CONTAINS: begin
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = S_SRCH_RD;
               end
               ACT_SORT_UP, ACT_SORT_DOWN: begin
                  cmd.ptr_op   = PTR_ZERO;
                  cmd.swap_clr = 1'b1;
                  state_in     = S_SORT_RD0;
               end
               ACT_CLEAR: begin
                  cmd.cnt_op = CNT_CLR;
                  state_in   = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         // linear search from ptr
         S_SRCH_RD: begin
            if (stat.at_end) begin
               if (stat.action == ACT_INS_SORTED) begin
                  cmd.pos_op = POS_PTR;
                  state_in   = S_UP_RD;
               end else begin
                  if (stat.action == ACT_REM_VALUE) begin
                     cmd.stat_ld   = 1'b1;
                     cmd.stat_code = STAT_MISSING;
                  end
                  state_in = S_RESP;
               end
            end else begin
               cmd.raddr = RA_PTR;
               state_in  = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (!stat.match) begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_SRCH_RD;
            end else if (stat.action == ACT_CONTAINS) begin
               cmd.found_set = 1'b1;
               state_in      = S_RESP;
            end else if (stat.action == ACT_INS_SORTED) begin
               cmd.pos_op = POS_PTR;
               cmd.ptr_op = PTR_COUNT;
               state_in   = S_UP_RD;
            end else begin
               cmd.rem_ld = 1'b1;
               state_in   = S_DN_RD;
            end
         end
         // open a hole at pos, then place the value
         S_UP_RD: begin
            if (stat.ptr_eq_pos) begin
               cmd.we     = 1'b1;
               cmd.waddr  = WA_PTR;
               cmd.wdata  = WD_VALUE;
               cmd.cnt_op = CNT_INC;
               state_in   = S_RESP;
            end else begin
               cmd.raddr = RA_PTR_M1;
               state_in  = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.we     = 1'b1;
            cmd.waddr  = WA_PTR;
            cmd.wdata  = WD_RDATA;
            cmd.ptr_op = PTR_DEC;
            state_in   = S_UP_RD;
         end
         // close the gap at ptr
         S_DN_RD: begin
            if (stat.pair_end) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_RESP;
            end else begin
               cmd.raddr = RA_PTR_P1;
               state_in  = S_DN_WR;
            end
         end
         S_DN_WR: begin
            cmd.we     = 1'b1;
            cmd.waddr  = WA_PTR;
            cmd.wdata  = WD_RDATA;
            cmd.ptr_op = PTR_INC;
            state_in   = S_DN_RD;
         end
         // bubble sort passes until one makes no swap
         S_SORT_RD0: begin
            if (stat.pair_end) begin
               cmd.ptr_op = PTR_ZERO;
               if (stat.swapped) begin
                  cmd.swap_clr = 1'b1;
                  state_in     = S_SORT_RD0;
               end else if (stat.action == ACT_INS_SORTED) begin
                  state_in = S_SRCH_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               cmd.raddr = RA_PTR;
               state_in  = S_SORT_RD1;
            end
         end
         S_SORT_RD1: begin
            cmd.raddr   = RA_PTR_P1;
            cmd.temp_ld = 1'b1;
            state_in    = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (stat.swap_need) begin
               cmd.we       = 1'b1;
               cmd.waddr    = WA_PTR;
               cmd.wdata    = WD_RDATA;
               cmd.swap_set = 1'b1;
               state_in     = S_SORT_WR;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_SORT_RD0;
            end
         end
         S_SORT_WR: begin
            cmd.we     = 1'b1;
            cmd.waddr  = WA_PTR_P1;
            cmd.wdata  = WD_TEMP;
            cmd.ptr_op = PTR_INC;
            state_in   = S_SORT_RD0;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.res_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

[rtl/ble_dpath.sv]
`default_nettype none
`include "assert_macros.svh"
module ble_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ble_pkg::cmd_type              cmd,
   output ble_pkg::stat_type                  stat,
   input  wire logic [ble_pkg::ACT_W-1:0]     req_action,
   input  wire logic signed [ble_pkg::VAL_W-1:0] req_value,
   input  wire logic                          csr_write_enable,
   input  wire logic [ble_pkg::CAP_W-1:0]     csr_write_data,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [ble_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ble_pkg::VAL_W-1:0]   rsp_removed_value,
   output logic                               rsp_found,
   output logic [ble_pkg::CNT_OUT_W-1:0]      rsp_entry_count,
   output logic                               rsp_is_empty
);
   import ble_pkg::*;

   logic [CAP_W-1:0]        cap_ff;
   logic [CNT_W-1:0]        count_ff, ptr_ff, pos_ff;
   logic [ACT_W-1:0]        action_ff;
   logic signed [VAL_W-1:0] value_ff, temp_ff, removed_ff;
   logic [STAT_W-1:0]       stat_ff;
   logic                    found_ff, swapped_ff, rsp_valid_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic signed [VAL_W-1:0] rsp_removed_ff;
   logic                    rsp_found_ff, rsp_empty_ff;
   logic [CNT_OUT_W-1:0]    rsp_count_ff;

   logic signed [VAL_W-1:0] rdata;
   logic [VAL_W-1:0]        rd_raw, wdata;
   logic [ADDR_W-1:0]       raddr, waddr;
   logic [CNT_W-1:0]        ptr_m1, ptr_p1;
   logic [CNT_W:0]          ptr_p1_wide;
   logic [LIM_W-1:0]        cap_ext, depth_ext, limit;

   // list storage
   ble_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rd_raw)
   );
   assign rdata = $signed(rd_raw);

   // address and data selection
   assign ptr_m1      = ptr_ff - 1'b1;
   assign ptr_p1      = ptr_ff + 1'b1;
   assign ptr_p1_wide = {1'b0, ptr_ff} + 1'b1;

   always_comb begin
      case (cmd.raddr)
         RA_PTR_M1: raddr = ptr_m1[ADDR_W-1:0];
         RA_PTR_P1: raddr = ptr_p1[ADDR_W-1:0];
         default:   raddr = ptr_ff[ADDR_W-1:0];
      endcase
      waddr = (cmd.waddr == WA_PTR_P1) ? ptr_p1[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
      case (cmd.wdata)
         WD_VALUE: wdata = value_ff;
         WD_TEMP:  wdata = temp_ff;
         default:  wdata = rd_raw;
      endcase
   end

   // effective capacity limit
   assign cap_ext   = LIM_W'(cap_ff);
   assign depth_ext = LIM_W'(DEPTH);
   assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;

   // status to the controller
   always_comb begin
      stat.action     = action_ff;
      stat.full       = LIM_W'(count_ff) >= limit;
      stat.empty      = count_ff == '0;
      stat.at_end     = ptr_ff == count_ff;
      stat.ptr_eq_pos = ptr_ff == pos_ff;
      stat.pair_end   = ptr_p1_wide >= {1'b0, count_ff};
      stat.swapped    = swapped_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.swap_need  = (action_ff == ACT_SORT_DOWN) ? (temp_ff < rdata) : (temp_ff > rdata);
      case (action_ff)
         ACT_INS_SORTED:              stat.match = rdata > value_ff;
         ACT_REM_VALUE, ACT_CONTAINS: stat.match = rdata == value_ff;
         default:                     stat.match = 1'b1;
      endcase
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // entry count and sort flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         swapped_ff <= 1'b0;
      end else begin
         case (cmd.cnt_op)
            CNT_INC: count_ff <= count_ff + 1'b1;
            CNT_DEC: count_ff <= count_ff - 1'b1;
            CNT_CLR: count_ff <= '0;
            default: count_ff <= count_ff;
         endcase
         if (cmd.swap_clr) begin
            swapped_ff <= 1'b0;
         end else if (cmd.swap_set) begin
            swapped_ff <= 1'b1;
         end
      end
   end

   // walk pointers, compare temp, request word and result fields
   always_ff @(posedge clock) begin
      case (cmd.ptr_op)
         PTR_ZERO:  ptr_ff <= '0;
         PTR_COUNT: ptr_ff <= count_ff;
         PTR_LAST:  ptr_ff <= count_ff - 1'b1;
         PTR_INC:   ptr_ff <= ptr_p1;
         PTR_DEC:   ptr_ff <= ptr_m1;
         default:   ptr_ff <= ptr_ff;
      endcase
      case (cmd.pos_op)
         POS_ZERO:  pos_ff <= '0;
         POS_COUNT: pos_ff <= count_ff;
         POS_PTR:   pos_ff <= ptr_ff;
         default:   pos_ff <= pos_ff;
      endcase
      if (cmd.temp_ld) begin
         temp_ff <= rdata;
      end
      if (cmd.start) begin
         action_ff  <= req_action;
         value_ff   <= req_value;
         stat_ff    <= STAT_OK;
         removed_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (cmd.stat_ld) begin
            stat_ff <= cmd.stat_code;
         end
         if (cmd.rem_ld) begin
            removed_ff <= rdata;
         end
         if (cmd.found_set) begin
            found_ff <= 1'b1;
         end
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_ld) begin
         rsp_status_ff  <= stat_ff;
         rsp_removed_ff <= removed_ff;
         rsp_found_ff   <= found_ff;
         rsp_count_ff   <= CNT_OUT_W'(count_ff);
         rsp_empty_ff   <= count_ff == '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;

   // checks
   `ASSERT_HOLDS(a_count_bound, clock, reset, LIM_W'(count_ff) <= depth_ext)
   `ASSERT_IMPLIES(a_inc_room, clock, reset, cmd.cnt_op == CNT_INC, LIM_W'(count_ff) < limit)
   `ASSERT_IMPLIES(a_dec_nonempty, clock, reset, cmd.cnt_op == CNT_DEC, count_ff != '0)
   `ASSERT_IMPLIES(a_write_in_range, clock, reset, cmd.we, ptr_p1_wide <= (CNT_W+1)'(DEPTH))
endmodule
`default_nettype wire

[dv/ble_list_checker.sv]
`default_nettype none
module ble_list_checker
   import ble_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   ble_req_if                     req_bus,
   ble_rsp_if                     rsp_bus,
   input  wire logic              csr_write_enable,
   input  wire logic [CAP_W-1:0]  csr_write_data,
   output int                     fail_count,
   output int                     pending
);

   typedef struct {
      status_type              status;
      logic signed [VAL_W-1:0] removed_value;
      logic                    found;
      logic [CNT_OUT_W-1:0]    entry_count;
      logic                    is_empty;
   } list_word_type;

   // shadow copy of the list and the capacity register
   logic signed [VAL_W-1:0] shadow_list [DEPTH];
   int                      shadow_len;
   logic [CAP_W-1:0]        shadow_cap;
   list_word_type           expected_words [$];

   assign pending = expected_words.size();

   // insertion sort over the occupied part of the list
   function automatic void order_list(bit descending);
      int                      j;
      logic signed [VAL_W-1:0] key;
      for (int i = 1; i < shadow_len; i++) begin
         key = shadow_list[i];
         j = i;
         while (j > 0 && (descending ? shadow_list[j-1] < key : shadow_list[j-1] > key)) begin
            shadow_list[j] = shadow_list[j-1];
            j--;
         end
         shadow_list[j] = key;
      end
   endfunction

   function automatic void place_at(int pos, logic signed [VAL_W-1:0] v);
      for (int k = shadow_len; k > pos; k--)
         shadow_list[k] = shadow_list[k-1];
      shadow_list[pos] = v;
      shadow_len++;
   endfunction

   function automatic void drop_at(int pos);
      for (int k = pos; k < shadow_len - 1; k++)
         shadow_list[k] = shadow_list[k+1];
      shadow_len--;
   endfunction

   // one request in, one predicted response word out
   function automatic list_word_type apply_request(logic [ACT_W-1:0] act,
                                                   logic signed [VAL_W-1:0] v);
      list_word_type w;
      int            limit;
      int            i;
      w.status = STAT_OK;
      w.removed_value = '0;
      w.found = 1'b0;
      limit = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
      case (act)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_SORTED: begin
            if (shadow_len >= limit) begin
               w.status = STAT_FULL;
            end else if (act == ACT_INS_FRONT) begin
               place_at(0, v);
            end else if (act == ACT_INS_BACK) begin
               place_at(shadow_len, v);
            end else begin
               order_list(1'b0);
               i = 0;
               while (i < shadow_len && shadow_list[i] <= v) i++;
               place_at(i, v);
            end
         end
         ACT_REM_FRONT, ACT_REM_BACK: begin
            if (shadow_len == 0) begin
               w.status = STAT_EMPTY;
            end else if (act == ACT_REM_FRONT) begin
               w.removed_value = shadow_list[0];
               drop_at(0);
            end else begin
               w.removed_value = shadow_list[shadow_len-1];
               shadow_len--;
            end
         end
         ACT_REM_VALUE: begin
            if (shadow_len == 0) begin
               w.status = STAT_EMPTY;
            end else begin
               i = 0;
               while (i < shadow_len && shadow_list[i] != v) i++;
               if (i == shadow_len) begin
                  w.status = STAT_MISSING;
               end else begin
                  w.removed_value = shadow_list[i];
                  drop_at(i);
               end
            end
         end
         ACT_CONTAINS: begin
            for (i = 0; i < shadow_len; i++)
               if (shadow_list[i] == v) w.found = 1'b1;
         end
         ACT_SORT_UP:   order_list(1'b0);
         ACT_SORT_DOWN: order_list(1'b1);
         ACT_CLEAR:     shadow_len = 0;
         default: ;
      endcase
      w.entry_count = shadow_len[CNT_OUT_W-1:0];
      w.is_empty = (shadow_len == 0);
      return w;
   endfunction

   // watch the three ports at every edge
   always @(posedge clock) begin
      list_word_type exp_w;
      if (reset) begin
         shadow_len = 0;
         shadow_cap = CAP_RESET;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (csr_write_enable)
            shadow_cap = csr_write_data;
         if (req_bus.valid && req_bus.ready)
            expected_words.push_back(apply_request(req_bus.action, req_bus.value));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_bus.status !== exp_w.status) begin
                  $error("status: expected %0d actual %0d", exp_w.status, rsp_bus.status);
                  fail_count++;
               end
               if (rsp_bus.removed_value !== exp_w.removed_value) begin
                  $error("removed_value: expected %0d actual %0d",
                         exp_w.removed_value, rsp_bus.removed_value);
                  fail_count++;
               end
               if (rsp_bus.found !== exp_w.found) begin
                  $error("found: expected %0d actual %0d", exp_w.found, rsp_bus.found);
                  fail_count++;
               end
               if (rsp_bus.entry_count !== exp_w.entry_count) begin
                  $error("entry_count: expected %0d actual %0d",
                         exp_w.entry_count, rsp_bus.entry_count);
                  fail_count++;
               end
               if (rsp_bus.is_empty !== exp_w.is_empty) begin
                  $error("is_empty: expected %0d actual %0d", exp_w.is_empty, rsp_bus.is_empty);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

[dv/tb_bounded_list_engine.sv]
`default_nettype none
module tb_bounded_list_engine;
   import ble_pkg::*;

   localparam int STALL_LIMIT = 300000;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CAP_W-1:0] csr_write_data;
   int               fail_count;
   int               pending;
   bit               gaps_on;
   bit               hold_rsp;
   int               idle_cycles = 0;

   ble_req_if req_bus ();
   ble_rsp_if rsp_bus ();

   bounded_list_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ble_list_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      int burst;
      bit hold_done;
      rsp_bus.ready <= 1'b0;
      burst = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end
         if (burst > 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 16) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // offer one request word and wait until it is taken
   task automatic send_word(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] v);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drain, then write the capacity register while idle
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3:    return $urandom;
         default: return $signed($urandom_range(0, 16)) - 8;
      endcase
   endfunction

   function automatic logic [ACT_W-1:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 14) return ACT_INS_FRONT;
      if (r < 28) return ACT_INS_BACK;
      if (r < 40) return ACT_INS_SORTED;
      if (r < 52) return ACT_REM_FRONT;
      if (r < 64) return ACT_REM_BACK;
      if (r < 78) return ACT_REM_VALUE;
      if (r < 88) return ACT_CONTAINS;
      if (r < 92) return ACT_SORT_UP;
      if (r < 95) return ACT_SORT_DOWN;
      if (r < 97) return ACT_CLEAR;
      return ACT_W'($urandom_range(10, 15));
   endfunction

   initial begin
      int caps [8];
      caps = '{1, 3, 8, 16, 24, 128, 100, 5};
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACT_CLEAR;
      req_bus.value    <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      gaps_on  = 1'b1;
      hold_rsp = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every action, the empty and missing cases
      send_word(ACT_INS_FRONT, 32'sh7fffffff);
      send_word(ACT_INS_BACK, 32'sh80000000);
      send_word(ACT_INS_SORTED, 0);
      send_word(ACT_INS_SORTED, 0);
      send_word(ACT_INS_SORTED, -1);
      send_word(ACT_CONTAINS, 32'sh80000000);
      send_word(ACT_CONTAINS, 5);
      send_word(ACT_REM_VALUE, 0);
      send_word(ACT_REM_VALUE, 7);
      send_word(ACT_SORT_DOWN, 0);
      send_word(ACT_SORT_UP, 0);
      send_word(ACT_REM_FRONT, 0);
      send_word(ACT_REM_BACK, 0);
      send_word(ACT_REM_BACK, 0);
      send_word(ACT_REM_FRONT, 0);
      send_word(ACT_REM_BACK, 0);
      send_word(ACT_REM_FRONT, 0);
      send_word(ACT_REM_VALUE, 3);
      send_word(ACT_CONTAINS, 0);
      send_word(ACT_SORT_UP, 0);
      send_word(4'd10, 0);
      send_word(4'd15, -1);
      send_word(ACT_CLEAR, 0);

      // capacity zero refuses every insert
      write_capacity(8'd0);
      send_word(ACT_INS_FRONT, 1);
      send_word(ACT_INS_BACK, 1);
      send_word(ACT_INS_SORTED, 1);

      // capacity one: the refused sorted insert leaves the list alone
      write_capacity(8'd1);
      send_word(ACT_INS_BACK, 3);
      send_word(ACT_INS_SORTED, -4);
      send_word(ACT_INS_FRONT, 9);
      send_word(ACT_CLEAR, 0);

      // capacity above the storage: one long hold-off at the start, fill to the depth
      write_capacity(8'd255);
      hold_rsp = 1'b1;
      for (int k = 0; k < DEPTH; k++)
         send_word(ACT_INS_BACK, pick_value());
      send_word(ACT_INS_FRONT, 1);
      send_word(ACT_SORT_DOWN, 0);
      send_word(ACT_CONTAINS, 32'sh7fffffff);
      send_word(ACT_REM_VALUE, 0);
      send_word(ACT_INS_SORTED, 2);
      send_word(ACT_CLEAR, 0);

      // random phases over several capacities
      for (int ph = 0; ph < 8; ph++) begin
         write_capacity(CAP_W'(caps[$urandom_range(0, 7)]));
         if (ph == 7) gaps_on = 1'b0;
         for (int k = 0; k < 110; k++)
            send_word(pick_action(), pick_value());
         send_word(ACT_CLEAR, 0);
      end
      req_bus.valid <= 1'b0;

      // drain and verdict
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
